// File: hdl/lacharger_pkg.sv
// Shared constants for the two-stage lead-acid charger: register map, widths and reset values.
package lacharger_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned VoltW     = 16;
  localparam int unsigned DutyW     = 8;

  // Register indexes on the configuration port
  localparam logic [CfgIndexW-1:0] RegMaxVoltage       = 3'd0;
  localparam logic [CfgIndexW-1:0] RegFloatVoltage     = 3'd1;
  localparam logic [CfgIndexW-1:0] RegReconnectVoltage = 3'd2;
  localparam logic [CfgIndexW-1:0] RegCheckInterval    = 3'd3;
  localparam logic [CfgIndexW-1:0] RegHoldTime         = 3'd4;

  // Register reset values
  localparam logic [VoltW-1:0] MaxVoltageReset       = 16'd14400;
  localparam logic [VoltW-1:0] FloatVoltageReset     = 16'd13700;
  localparam logic [VoltW-1:0] ReconnectVoltageReset = 16'd12600;
  localparam logic [VoltW-1:0] CheckIntervalReset    = 16'd50;
  localparam logic [TimeW-1:0] HoldTimeReset         = 32'd3600000;

  // Duty limits: full duty (driven in main charge) and zero
  localparam logic [DutyW-1:0] DutyFull = 8'hFF;
  localparam logic [DutyW-1:0] DutyZero = 8'h00;

  // Charge modes
  localparam logic ModeMain  = 1'b0;
  localparam logic ModeFloat = 1'b1;

endpackage

// File: hdl/lead_acid_two_stage_charger_top.sv
// Two-stage lead-acid charger controller: input register, control step, result register.
// A word accepted at the input goes through the input register and then the result register.
// Throughput: one word per cycle while the output is not stalled; the interval and hold checks are one 32-bit subtract
// and compare each between the input register and the result/state registers.
// Reset (rst, synchronous): main mode, duty 0, hold timer stopped, last step time 0,
// configuration registers back to their defaults; pipeline emptied.
module lead_acid_two_stage_charger_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lacharger_pkg::TimeW-1:0]       now_ms,
  input  logic [lacharger_pkg::VoltW-1:0]       battery_mv,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lacharger_pkg::DutyW-1:0]       pwm_duty,
  output logic                                  charge_mode,
  output logic                                  step_taken,
  // configuration port
  input  logic                                  cfg_write,
  input  logic [lacharger_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [lacharger_pkg::CfgDataW-1:0]    cfg_data
);

  import lacharger_pkg::*;

  // configuration registers
  logic [VoltW-1:0] max_voltage;
  logic [VoltW-1:0] float_voltage;
  logic [VoltW-1:0] reconnect_voltage;
  logic [VoltW-1:0] check_interval;
  logic [TimeW-1:0] hold_time;

  // controller state
  logic             mode;
  logic [DutyW-1:0] duty;
  logic [TimeW-1:0] hold_start;
  logic             hold_running;
  logic [TimeW-1:0] last_step_time;

  // input register
  logic             s1_valid;
  logic [TimeW-1:0] s1_now;
  logic [VoltW-1:0] s1_mv;

  logic             s1_advance;
  logic             s1_fire;
  logic             s1_step;
  logic [TimeW-1:0] since_step;
  logic [TimeW-1:0] since_hold;
  logic             mode_next;
  logic [DutyW-1:0] duty_next;
  logic [TimeW-1:0] hold_start_next;
  logic             hold_running_next;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_voltage       <= MaxVoltageReset;
      float_voltage     <= FloatVoltageReset;
      reconnect_voltage <= ReconnectVoltageReset;
      check_interval    <= CheckIntervalReset;
      hold_time         <= HoldTimeReset;
    end else if (cfg_write) begin
      case (cfg_index)
        RegMaxVoltage:       max_voltage       <= cfg_data[VoltW-1:0];
        RegFloatVoltage:     float_voltage     <= cfg_data[VoltW-1:0];
        RegReconnectVoltage: reconnect_voltage <= cfg_data[VoltW-1:0];
        RegCheckInterval:    check_interval    <= cfg_data[VoltW-1:0];
        RegHoldTime:         hold_time         <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the input register moves on whenever the result register is free
  assign s1_advance = !out_valid || !out_stall;
  assign s1_fire    = s1_valid && s1_advance;
  assign in_stall   = s1_valid && !s1_advance;

  // hold the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_now <= now_ms;
      s1_mv  <= battery_mv;
    end
  end

  // check elapsed times with wrapping subtraction
  assign since_step = s1_now - last_step_time;
  assign s1_step    = since_step >= {{(TimeW-VoltW){1'b0}}, check_interval};
  assign since_hold = hold_running ? (s1_now - hold_start) : '0;

  // compute the control step
  always_comb begin
    mode_next         = mode;
    duty_next         = duty;
    hold_start_next   = hold_start;
    hold_running_next = hold_running;
    if (mode == ModeMain) begin
      duty_next = DutyFull;
      if (s1_mv >= max_voltage) begin
        if (!hold_running) begin
          hold_start_next   = s1_now;
          hold_running_next = 1'b1;
        end
        if (since_hold > hold_time) begin
          mode_next = ModeFloat;
        end
      end else begin
        hold_running_next = 1'b0;
      end
    end else begin
      if (s1_mv < float_voltage && duty != DutyFull) begin
        duty_next = duty + 8'd1;
      end else if (s1_mv > float_voltage && duty != DutyZero) begin
        duty_next = duty - 8'd1;
      end
      if (s1_mv < reconnect_voltage) begin
        mode_next         = ModeMain;
        hold_running_next = 1'b0;
      end
    end
  end

  // advance controller state on a word that takes a step
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= ModeMain;
      duty           <= DutyZero;
      hold_start     <= '0;
      hold_running   <= 1'b0;
      last_step_time <= '0;
    end else if (s1_fire && s1_step) begin
      mode           <= mode_next;
      duty           <= duty_next;
      hold_start     <= hold_start_next;
      hold_running   <= hold_running_next;
      last_step_time <= s1_now;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pwm_duty    <= s1_step ? duty_next : duty;
      charge_mode <= s1_step ? mode_next : mode;
      step_taken  <= s1_step;
    end
  end

  // a step in main mode always drives full duty
  a_main_full_duty: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_step && (mode == ModeMain) |=> pwm_duty == DutyFull)
    else $error("main-mode step did not drive full duty");

  // state moves only on a word that takes a step
  a_state_quiet: assert property (@(posedge clk) disable iff (rst)
    !(s1_fire && s1_step) |=> $stable(mode) && $stable(duty) && $stable(last_step_time))
    else $error("controller state changed without a step");

  // float mode moves duty by at most one per step
  a_float_slew: assert property (@(posedge clk) disable iff (rst)
    s1_fire && (mode == ModeFloat) |=>
      (duty == $past(duty)) || (duty == $past(duty) + 8'd1) || (duty == $past(duty) - 8'd1))
    else $error("float duty moved by more than one");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && s1_valid)
    else $error("input stalled with a free result register");

endmodule

// File: tb/lead_acid_two_stage_charger_top_test.sv
// Testbench for the two-stage lead-acid charger: directed and random words checked against a predictor.
`timescale 1ns / 1ps
module lead_acid_two_stage_charger_top_test;
  import lacharger_pkg::*;

  // Index past the end of the register map; writes to it must be dropped
  localparam logic [CfgIndexW-1:0] RegBeyondMap = 3'd6;

  typedef struct packed {
    logic [TimeW-1:0] now;
    logic [VoltW-1:0] mv;
  } reading_t;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             mode;
    logic             stepped;
  } charge_out_t;

  typedef enum int {
    BandHigh, BandAboveFloat, BandBelowFloat, BandLow, BandEdge, BandNoise
  } volt_band_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TimeW-1:0]     now_ms = '0;
  logic [VoltW-1:0]     battery_mv = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DutyW-1:0]     pwm_duty;
  logic                 charge_mode;
  logic                 step_taken;
  logic                 cfg_write = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = RegMaxVoltage;
  logic [CfgDataW-1:0]  cfg_data = '0;

  // Predictor copy of the configuration and the charger state
  logic [VoltW-1:0] m_max_v;
  logic [VoltW-1:0] m_float_v;
  logic [VoltW-1:0] m_reconnect_v;
  logic [VoltW-1:0] m_interval;
  logic [TimeW-1:0] m_hold_time;
  logic             m_mode;
  logic [DutyW-1:0] m_duty;
  logic [TimeW-1:0] m_hold_start;
  logic             m_hold_run;
  logic [TimeW-1:0] m_last_step;

  reading_t    pending_readings[$];
  charge_out_t predicted_outputs[$];
  int          mismatches = 0;
  int          send_wait = 0;
  int          recv_wait = 0;
  bit          idle_on = 1'b1;
  logic [TimeW-1:0] clock_now;

  lead_acid_two_stage_charger_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .now_ms      (now_ms),
    .battery_mv  (battery_mv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pwm_duty    (pwm_duty),
    .charge_mode (charge_mode),
    .step_taken  (step_taken),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void reset_model();
    m_max_v       = MaxVoltageReset;
    m_float_v     = FloatVoltageReset;
    m_reconnect_v = ReconnectVoltageReset;
    m_interval    = CheckIntervalReset;
    m_hold_time   = HoldTimeReset;
    m_mode        = ModeMain;
    m_duty        = DutyZero;
    m_hold_start  = '0;
    m_hold_run    = 1'b0;
    m_last_step   = '0;
  endfunction

  // Mirror a register write, masked to the register width
  function automatic void set_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      RegMaxVoltage:       m_max_v = data[VoltW-1:0];
      RegFloatVoltage:     m_float_v = data[VoltW-1:0];
      RegReconnectVoltage: m_reconnect_v = data[VoltW-1:0];
      RegCheckInterval:    m_interval = data[VoltW-1:0];
      RegHoldTime:         m_hold_time = data[TimeW-1:0];
      default: ;
    endcase
  endfunction

  // Advance the charger by one reading and return the result it reports
  function automatic charge_out_t charger_step(reading_t r);
    charge_out_t      res;
    logic [TimeW-1:0] since_step;
    logic [TimeW-1:0] held;
    since_step = r.now - m_last_step;
    res.stepped = 1'b0;
    if (since_step >= TimeW'(m_interval)) begin
      res.stepped = 1'b1;
      if (m_mode == ModeMain) begin
        m_duty = DutyFull;
        if (r.mv >= m_max_v) begin
          if (!m_hold_run) begin
            m_hold_start = r.now;
            m_hold_run = 1'b1;
          end
          held = r.now - m_hold_start;
          if (held > m_hold_time) m_mode = ModeFloat;
        end else begin
          m_hold_run = 1'b0;
        end
      end else begin
        if (r.mv < m_float_v && m_duty != DutyFull) m_duty = m_duty + 1'b1;
        if (r.mv > m_float_v && m_duty != DutyZero) m_duty = m_duty - 1'b1;
        if (r.mv < m_reconnect_v) begin
          m_mode = ModeMain;
          m_hold_run = 1'b0;
        end
      end
      m_last_step = r.now;
    end
    res.duty = m_duty;
    res.mode = m_mode;
    return res;
  endfunction

  function automatic int pause_len();
    return idle_on ? int'($urandom_range(0, 8)) : 0;
  endfunction

  // Time advance, mostly around the check interval, with rare wraps and jumps back
  function automatic logic [TimeW-1:0] time_step();
    int unsigned      pick;
    int unsigned      span;
    logic [TimeW-1:0] dt;
    pick = $urandom_range(0, 31);
    span = m_interval;
    if (pick == 0) dt = $urandom;
    else if (pick == 1) begin
      dt = '0;
      dt = dt - $urandom_range(1, 100);
    end else if (pick < 5) dt = span;
    else if (pick < 7) dt = (span == 0) ? '0 : span - 1;
    else if (pick < 9) dt = '0;
    else dt = $urandom_range(span / 2, span * 2 + 3);
    return dt;
  endfunction

  // Voltage close to one of the thresholds, clamped to the field range
  function automatic logic [VoltW-1:0] pick_voltage(volt_band_t band);
    int v;
    case (band)
      BandHigh:       v = int'(m_max_v) + int'($urandom_range(0, 60));
      BandAboveFloat: v = int'(m_float_v) + int'($urandom_range(1, 60));
      BandBelowFloat: v = int'(m_float_v) - int'($urandom_range(1, 60));
      BandLow:        v = int'(m_reconnect_v) - int'($urandom_range(1, 300));
      BandEdge: begin
        case ($urandom_range(0, 6))
          0: v = int'(m_max_v);
          1: v = int'(m_max_v) - 1;
          2: v = int'(m_float_v);
          3: v = int'(m_reconnect_v);
          4: v = int'(m_reconnect_v) - 1;
          5: v = 0;
          default: v = 65535;
        endcase
      end
      default: v = int'($urandom_range(0, 65535));
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return VoltW'(v);
  endfunction

  // Drive input words from the pending queue, with a random gap before each
  always @(posedge clk) begin : drive_inputs
    reading_t word;
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && !in_stall) predicted_outputs.push_back(charger_step({now_ms, battery_mv}));
      if (!(in_valid && in_stall)) begin
        if (send_wait != 0) begin
          in_valid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_readings.size() != 0) begin
          word = pending_readings.pop_front();
          now_ms <= word.now;
          battery_mv <= word.mv;
          in_valid <= 1'b1;
          send_wait <= pause_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Compare each result word with the oldest prediction; stall at random
  always @(posedge clk) begin : check_outputs
    charge_out_t want;
    int          n;
    if (rst) begin
      out_stall <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word: duty %0d mode %0d step %0d",
                   $time, pwm_duty, charge_mode, step_taken);
        end else begin
          want = predicted_outputs.pop_front();
          if (pwm_duty !== want.duty) begin
            mismatches++;
            $display("%0t: pwm_duty expected %0d got %0d", $time, want.duty, pwm_duty);
          end
          if (charge_mode !== want.mode) begin
            mismatches++;
            $display("%0t: charge_mode expected %0d got %0d", $time, want.mode, charge_mode);
          end
          if (step_taken !== want.stepped) begin
            mismatches++;
            $display("%0t: step_taken expected %0d got %0d", $time, want.stepped, step_taken);
          end
        end
      end
      if (recv_wait != 0) begin
        out_stall <= 1'b1;
        recv_wait <= recv_wait - 1;
      end else if (out_valid && !out_stall) begin
        n = pause_len();
        out_stall <= (n != 0);
        recv_wait <= (n != 0) ? n - 1 : 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_reading(logic [TimeW-1:0] t, logic [VoltW-1:0] v);
    reading_t r;
    r.now = t;
    r.mv = v;
    pending_readings.push_back(r);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    set_reg(idx, data);
  endtask

  // Wait until every queued word went in and every result came back; sample
  // between edges so the driver's updates for the edge have settled
  task automatic wait_idle();
    @(negedge clk);
    while (pending_readings.size() != 0 || in_valid || predicted_outputs.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Load a full register set; the first two calls use the extremes
  task automatic random_settings(int k);
    logic [VoltW-1:0] rc;
    logic [VoltW-1:0] fl;
    logic [VoltW-1:0] mx;
    logic [VoltW-1:0] ivl;
    logic [TimeW-1:0] hold;
    rc = VoltW'($urandom_range(10000, 12800));
    fl = rc + VoltW'($urandom_range(0, 1500));
    mx = fl + VoltW'($urandom_range(0, 1500));
    ivl = VoltW'($urandom_range(0, 100));
    hold = $urandom_range(0, 400);
    if (k == 0) begin
      mx = '1;
      fl = '0;
      rc = '0;
      ivl = '1;
      hold = '1;
    end else if (k == 1) begin
      mx = '0;
      fl = '1;
      rc = '1;
      ivl = '0;
      hold = '0;
    end
    write_reg(RegMaxVoltage, {VoltW'($urandom), mx});
    write_reg(RegFloatVoltage, {VoltW'($urandom), fl});
    write_reg(RegReconnectVoltage, {VoltW'($urandom), rc});
    write_reg(RegCheckInterval, {VoltW'($urandom), ivl});
    write_reg(RegHoldTime, hold);
  endtask

  // Segments of readings that stay in one voltage band, with some noise mixed in
  task automatic random_phase(int n);
    int         left;
    int         seg;
    volt_band_t band;
    left = n;
    clock_now = $urandom;
    while (left > 0) begin
      band = volt_band_t'($urandom_range(0, 5));
      seg = $urandom_range(3, 40);
      if (seg > left) seg = left;
      repeat (seg) begin
        clock_now = clock_now + time_step();
        queue_reading(clock_now, ($urandom_range(0, 9) == 0) ? pick_voltage(BandNoise)
                                                           : pick_voltage(band));
      end
      left = left - seg;
    end
  endtask

  task automatic band_run(volt_band_t band, int n);
    repeat (n) begin
      clock_now = clock_now + time_step();
      queue_reading(clock_now, pick_voltage(band));
    end
  endtask

  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Defaults: early items, hold timer edge, float regulation, reconnect, time wrap
    queue_reading(0, 0);
    queue_reading(49, 14400);
    queue_reading(50, 14400);
    queue_reading(3600050, 14400);
    queue_reading(3600051, 65535);
    queue_reading(3600101, 65535);
    queue_reading(3600151, 13700);
    queue_reading(3600201, 13701);
    queue_reading(3600251, 13700);
    queue_reading(3600301, 14399);
    queue_reading(3600351, 12599);
    queue_reading(3600351, 14400);
    queue_reading(3600401, 14400);
    queue_reading(3600451, 14399);
    queue_reading(32'hFFFF_FFFF, 0);
    queue_reading(32'h0000_0030, 65535);
    queue_reading(32'h0000_0031, 0);
    wait_idle();

    // Zero interval and zero hold time; hold timer started at time zero
    write_reg(RegCheckInterval, 32'd0);
    write_reg(RegHoldTime, 32'd0);
    write_reg(RegBeyondMap, 32'hDEAD_BEEF);
    queue_reading(0, 14400);
    queue_reading(0, 14400);
    queue_reading(1, 14400);
    queue_reading(1, 0);
    wait_idle();

    // Charge to float, then pull the duty down to zero and back up, then reconnect
    idle_on = 1'b0;
    write_reg(RegMaxVoltage, 32'd14000);
    write_reg(RegFloatVoltage, 32'd13500);
    write_reg(RegReconnectVoltage, 32'd12000);
    write_reg(RegHoldTime, 32'd10);
    clock_now = $urandom;
    band_run(BandHigh, 30);
    band_run(BandAboveFloat, 300);
    band_run(BandBelowFloat, 40);
    band_run(BandLow, 5);
    wait_idle();

    // Random settings and readings; idling switched on in alternate phases
    for (int k = 0; k < 5; k++) begin
      idle_on = (k % 2 == 0);
      random_settings(k);
      random_phase(130);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
hdl/lacharger_pkg.sv
hdl/lead_acid_two_stage_charger_top.sv
tb/lead_acid_two_stage_charger_top_test.sv
